>>> hdl/i2cee_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C EEPROM byte access master package
// Shared types and constants: bus phase codes, register indexes, state and
// configuration records passed between the modules.
// ----------------------------------------------------------------------------
package i2cee_pkg;

	// Bus phases of one transaction.
	typedef enum logic [4:0] {
		PH_IDLE      = 5'd0,
		PH_ST_SDA_HI = 5'd1,
		PH_ST_SCL_HI = 5'd2,
		PH_ST_SDA_LO = 5'd3,
		PH_ST_SCL_LO = 5'd4,
		PH_TX_SET    = 5'd5,
		PH_TX_HI     = 5'd6,
		PH_TX_LO     = 5'd7,
		PH_ACK_REL   = 5'd8,
		PH_ACK_HI    = 5'd9,
		PH_ACK_POLL  = 5'd10,
		PH_RX_REL    = 5'd11,
		PH_RX_HI     = 5'd12,
		PH_RX_SAMPLE = 5'd13,
		PH_RX_LO     = 5'd14,
		PH_NK_SDA    = 5'd15,
		PH_NK_HI     = 5'd16,
		PH_NK_LO     = 5'd17,
		PH_SP_SDA_LO = 5'd18,
		PH_SP_SCL_HI = 5'd19,
		PH_SP_SDA_HI = 5'd20,
		PH_WAIT      = 5'd21
	} phase_t;

	// Configuration register indexes.
	localparam logic [1:0] REG_CHIP_SELECT    = 2'd0;
	localparam logic [1:0] REG_ACK_POLL_LIMIT = 2'd1;
	localparam logic [1:0] REG_RECOVERY_TICKS = 2'd2;

	// Device byte bases: 1010 prefix with write or read direction bit.
	localparam logic [7:0] DEV_WRITE = 8'hA0;
	localparam logic [7:0] DEV_READ  = 8'hA1;

	// Byte sequence points, counted after each acknowledged byte.
	localparam logic [2:0] STEP_ADDRESS = 3'd1;
	localparam logic [2:0] STEP_SECOND  = 3'd2;

	localparam int CFG_DATA_W = 16;

	typedef struct packed {
		logic [2:0]  chip_select;
		logic [7:0]  ack_poll_limit;
		logic [15:0] recovery_ticks;
	} cfg_t;

	// Sequencer state except the parameterized wait counter.
	typedef struct packed {
		phase_t      phase;
		logic [2:0]  byte_step;
		logic [3:0]  bit_count;
		logic [7:0]  shift_byte;
		logic [7:0]  held_address;
		logic [7:0]  held_data;
		logic        held_mode;
		logic [7:0]  result_byte;
		logic        error_flag;
		logic        scl_drive;
		logic        sda_drive;
	} seq_state_t;

endpackage

>>> hdl/i2c_eeprom_byte_access_master_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C EEPROM byte access master
// Bit-level master for byte write and random byte read of a serial EEPROM.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the s_ channel is one bus phase tick. tdata carries the
// transaction request, the read/write mode, address, write byte and the
// sampled SDA level. For every accepted tick exactly one result request
// leaves on the m_ channel with the SCL and SDA drive levels, busy, a done
// pulse, the last byte read and the sticky missing-ACK flag.
// A tick's result is registered: it sits in the output register in the
// cycle after acceptance. Throughput is one tick per clock while results
// are taken; the sequencer steps once per accepted tick, in one pass of logic.
// When the receiver stalls, the output register holds its result and s_tready
// stays high only if that result is taken in the same cycle.
// Configuration writes on the cfg_ channel are always taken (cfg_ready high);
// index 0 chip select, 1 ACK poll limit, 2 recovery ticks.
// Reset puts the sequencer idle with both lines released and clears the
// read byte and error flag; registers return to 0, 93 and 2500.
// ----------------------------------------------------------------------------
module i2c_eeprom_byte_access_master_unit
	import i2cee_pkg::*;
#(
	parameter int WAIT_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Tick input.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// Low bit up: request, read_not_write, mem_address[7:0], write_data[7:0],
	// sda_in, zero pad.
	input  logic [23:0]           s_tdata,
	// Tick result.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// Low bit up: scl_level, sda_level, busy_res, done_res, read_byte[7:0],
	// ack_missing, zero pad.
	output logic [15:0]           m_tdata,
	// Configuration writes.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t                  cfg;
	seq_state_t            state_q;
	seq_state_t            state_nxt;
	logic [WAIT_WIDTH-1:0] wait_q;
	logic [WAIT_WIDTH-1:0] wait_nxt;
	logic                  done_nxt;
	logic                  in_accept;
	logic                  out_valid_q;
	logic [15:0]           out_data_q;

	assign cfg_ready = 1'b1;

	i2cee_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	i2cee_step #(
		.WAIT_WIDTH (WAIT_WIDTH)
	) u_step (
		.cur            (state_q),
		.wait_cur       (wait_q),
		.cfg            (cfg),
		.request        (s_tdata[0]),
		.read_not_write (s_tdata[1]),
		.mem_address    (s_tdata[9:2]),
		.write_data     (s_tdata[17:10]),
		.sda_in         (s_tdata[18]),
		.nxt            (state_nxt),
		.wait_nxt       (wait_nxt),
		.done           (done_nxt)
	);

	// A new tick is taken whenever the output register is free or draining.
	assign s_tready  = !out_valid_q || m_tready;
	assign in_accept = s_tvalid && s_tready;

	// Sequencer state advances once per accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase        <= PH_IDLE;
			state_q.byte_step    <= 3'd0;
			state_q.bit_count    <= 4'd0;
			state_q.shift_byte   <= 8'd0;
			state_q.held_address <= 8'd0;
			state_q.held_data    <= 8'd0;
			state_q.held_mode    <= 1'b0;
			state_q.result_byte  <= 8'd0;
			state_q.error_flag   <= 1'b0;
			state_q.scl_drive    <= 1'b1;
			state_q.sda_drive    <= 1'b1;
			wait_q               <= '0;
		end else if (in_accept) begin
			state_q <= state_nxt;
			wait_q  <= wait_nxt;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload captured with the tick.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			out_data_q <= {3'd0, state_nxt.error_flag, state_nxt.result_byte, done_nxt,
				(state_nxt.phase != PH_IDLE), state_nxt.sda_drive, state_nxt.scl_drive};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

>>> hdl/i2cee_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C EEPROM master configuration registers
// Holds chip select, ACK poll limit and recovery time; writes land at once.
// ----------------------------------------------------------------------------
module i2cee_cfg_regs
	import i2cee_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [1:0]            wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Register file update; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chip_select    <= 3'd0;
			cfg_q.ack_poll_limit <= 8'd93;
			cfg_q.recovery_ticks <= 16'd2500;
		end else if (wr_en) begin
			case (wr_index)
				REG_CHIP_SELECT:    cfg_q.chip_select    <= wr_data[2:0];
				REG_ACK_POLL_LIMIT: cfg_q.ack_poll_limit <= wr_data[7:0];
				REG_RECOVERY_TICKS: cfg_q.recovery_ticks <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hdl/i2cee_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C EEPROM master phase step
// Combinational next state for one bus phase tick: line drive, byte shift,
// ACK polling, read capture and recovery countdown.
// ----------------------------------------------------------------------------
module i2cee_step
	import i2cee_pkg::*;
#(
	parameter int WAIT_WIDTH = 16
) (
	input  seq_state_t            cur,
	input  logic [WAIT_WIDTH-1:0] wait_cur,
	input  cfg_t                  cfg,
	input  logic                  request,
	input  logic                  read_not_write,
	input  logic [7:0]            mem_address,
	input  logic [7:0]            write_data,
	input  logic                  sda_in,
	output seq_state_t            nxt,
	output logic [WAIT_WIDTH-1:0] wait_nxt,
	output logic                  done
);

	logic [7:0]            poll_limit;
	logic [WAIT_WIDTH-1:0] poll_count;
	logic                  poll_timeout;
	logic                  poll_end;
	logic [2:0]            ack_step;
	logic                  ack_load;
	logic [7:0]            ack_byte;
	phase_t                ack_phase;
	logic [7:0]            dev_byte;
	phase_t                phase_nxt;

	// ACK polling: a limit of zero behaves as one.
	assign poll_limit   = (cfg.ack_poll_limit == 8'd0) ? 8'd1 : cfg.ack_poll_limit;
	assign poll_count   = wait_cur + WAIT_WIDTH'(1);
	assign poll_timeout = (poll_count >= WAIT_WIDTH'(poll_limit))
		|| (poll_count == '0);
	assign poll_end     = !sda_in || poll_timeout;

	// Device byte for the start that just finished.
	assign dev_byte = ((cur.byte_step == STEP_SECOND) ? DEV_READ : DEV_WRITE)
		| {4'd0, cfg.chip_select, 1'b0};

	// What follows an acknowledged byte.
	always_comb begin
		ack_step  = cur.byte_step + 3'd1;
		ack_load  = 1'b0;
		ack_byte  = cur.held_address;
		ack_phase = PH_SP_SDA_LO;
		if (ack_step == STEP_ADDRESS) begin
			ack_load  = 1'b1;
			ack_phase = PH_TX_SET;
		end else if (!cur.held_mode) begin
			if (ack_step == STEP_SECOND) begin
				ack_load  = 1'b1;
				ack_byte  = cur.held_data;
				ack_phase = PH_TX_SET;
			end
		end else begin
			ack_phase = (ack_step == STEP_SECOND) ? PH_ST_SDA_HI : PH_RX_REL;
		end
	end

	// Next phase.
	always_comb begin
		phase_nxt = cur.phase;
		case (cur.phase)
			PH_IDLE:      if (request) phase_nxt = PH_ST_SDA_HI;
			PH_ST_SDA_HI: phase_nxt = PH_ST_SCL_HI;
			PH_ST_SCL_HI: phase_nxt = PH_ST_SDA_LO;
			PH_ST_SDA_LO: phase_nxt = PH_ST_SCL_LO;
			PH_ST_SCL_LO: phase_nxt = PH_TX_SET;
			PH_TX_SET:    phase_nxt = PH_TX_HI;
			PH_TX_HI:     phase_nxt = PH_TX_LO;
			PH_TX_LO:     phase_nxt = (cur.bit_count + 4'd1 >= 4'd8) ? PH_ACK_REL : PH_TX_SET;
			PH_ACK_REL:   phase_nxt = PH_ACK_HI;
			PH_ACK_HI:    phase_nxt = PH_ACK_POLL;
			PH_ACK_POLL:  if (poll_end) phase_nxt = ack_phase;
			PH_RX_REL:    phase_nxt = PH_RX_HI;
			PH_RX_HI:     phase_nxt = PH_RX_SAMPLE;
			PH_RX_SAMPLE: phase_nxt = PH_RX_LO;
			PH_RX_LO:     phase_nxt = (cur.bit_count + 4'd1 >= 4'd8) ? PH_NK_SDA : PH_RX_HI;
			PH_NK_SDA:    phase_nxt = PH_NK_HI;
			PH_NK_HI:     phase_nxt = PH_NK_LO;
			PH_NK_LO:     phase_nxt = PH_SP_SDA_LO;
			PH_SP_SDA_LO: phase_nxt = PH_SP_SCL_HI;
			PH_SP_SCL_HI: phase_nxt = PH_SP_SDA_HI;
			PH_SP_SDA_HI: phase_nxt = PH_WAIT;
			PH_WAIT:      if (wait_cur == '0) phase_nxt = PH_IDLE;
			default:      phase_nxt = PH_IDLE;
		endcase
	end

	// Datapath and line drive for this tick.
	always_comb begin
		nxt       = cur;
		nxt.phase = phase_nxt;
		wait_nxt  = wait_cur;
		done      = 1'b0;
		case (cur.phase)
			PH_IDLE: begin
				if (request) begin
					nxt.held_mode    = read_not_write;
					nxt.held_address = mem_address;
					nxt.held_data    = write_data;
					nxt.error_flag   = 1'b0;
					nxt.byte_step    = 3'd0;
					nxt.bit_count    = 4'd0;
				end
			end
			PH_ST_SDA_HI: nxt.sda_drive = 1'b1;
			PH_ST_SCL_HI: nxt.scl_drive = 1'b1;
			PH_ST_SDA_LO: nxt.sda_drive = 1'b0;
			PH_ST_SCL_LO: begin
				nxt.scl_drive  = 1'b0;
				nxt.shift_byte = dev_byte;
				nxt.bit_count  = 4'd0;
			end
			PH_TX_SET: nxt.sda_drive = cur.shift_byte[7];
			PH_TX_HI:  nxt.scl_drive = 1'b1;
			PH_TX_LO: begin
				nxt.scl_drive  = 1'b0;
				nxt.shift_byte = {cur.shift_byte[6:0], 1'b0};
				nxt.bit_count  = cur.bit_count + 4'd1;
			end
			PH_ACK_REL: nxt.sda_drive = 1'b1;
			PH_ACK_HI: begin
				nxt.scl_drive = 1'b1;
				wait_nxt      = '0;
			end
			PH_ACK_POLL: begin
				if (sda_in) begin
					wait_nxt = poll_count;
				end
				if (poll_end) begin
					nxt.scl_drive = 1'b0;
					nxt.byte_step = ack_step;
					if (sda_in) begin
						nxt.error_flag = 1'b1;
					end
					if (ack_load) begin
						nxt.shift_byte = ack_byte;
						nxt.bit_count  = 4'd0;
					end
				end
			end
			PH_RX_REL: begin
				nxt.sda_drive  = 1'b1;
				nxt.bit_count  = 4'd0;
				nxt.shift_byte = 8'd0;
			end
			PH_RX_HI:     nxt.scl_drive = 1'b1;
			PH_RX_SAMPLE: nxt.shift_byte = {cur.shift_byte[6:0], sda_in};
			PH_RX_LO: begin
				nxt.scl_drive = 1'b0;
				nxt.bit_count = cur.bit_count + 4'd1;
				if (cur.bit_count + 4'd1 >= 4'd8) begin
					nxt.result_byte = cur.shift_byte;
				end
			end
			PH_NK_SDA:    nxt.sda_drive = 1'b1;
			PH_NK_HI:     nxt.scl_drive = 1'b1;
			PH_NK_LO:     nxt.scl_drive = 1'b0;
			PH_SP_SDA_LO: nxt.sda_drive = 1'b0;
			PH_SP_SCL_HI: nxt.scl_drive = 1'b1;
			PH_SP_SDA_HI: begin
				nxt.sda_drive = 1'b1;
				wait_nxt      = WAIT_WIDTH'(cfg.recovery_ticks);
			end
			PH_WAIT: begin
				if (wait_cur == '0) begin
					done = 1'b1;
				end else begin
					wait_nxt = wait_cur - WAIT_WIDTH'(1);
				end
			end
			default: ;
		endcase
	end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the I2C EEPROM byte access master
// Sends bus phase ticks, byte writes and random reads with acknowledges that
// come at once, late or never, and compares every tick result with a cycle
// model of the phase sequencer kept inside the bench.
// ----------------------------------------------------------------------------
module tb;
	import i2cee_pkg::*;

	// One tick request; the first member sits in the top bits.
	typedef struct packed {
		logic       sda;
		logic [7:0] wdata;
		logic [7:0] addr;
		logic       rnw;
		logic       req;
	} tick_t;

	// One tick result, packed like the low bits of m_tdata.
	typedef struct packed {
		logic       ack_missing;
		logic [7:0] read_byte;
		logic       done;
		logic       busy;
		logic       sda;
		logic       scl;
	} result_t;

	// How the simulated memory answers the acknowledge poll.
	typedef enum logic [1:0] {ACK_PROMPT, ACK_SLOW, ACK_NONE} ack_style_t;

	// Ready patterns of the result receiver.
	typedef enum logic [1:0] {SINK_OPEN, SINK_RANDOM, SINK_PATTERN} sink_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [23:0]           s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [15:0]           m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [1:0]            cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Bench copy of the sequencer state and registers.
	phase_t      bus_phase;
	logic [2:0]  byte_step;
	logic [3:0]  bit_cnt;
	logic [7:0]  shift_reg;
	logic [15:0] wait_cnt;
	logic [7:0]  held_addr;
	logic [7:0]  held_data;
	logic        held_mode;
	logic [7:0]  rd_byte;
	logic        err_flag;
	logic        scl_drv;
	logic        sda_drv;
	logic [2:0]  chip_sel;
	logic [7:0]  poll_limit;
	logic [15:0] recovery;

	result_t     tick_results_due[$];
	result_t     seen_res;
	result_t     want_res;

	int          mismatches = 0;
	int          checked = 0;
	int          ticks_sent = 0;
	int          writes_started = 0;
	int          reads_started = 0;
	int          missing_ack_xfers = 0;
	int          settings_applied = 0;
	int          burst_left = 0;
	int          sink_age = 0;
	sink_mode_t  sink_mode = SINK_OPEN;
	logic [7:0]  sink_mask = 8'hFF;

	i2c_eeprom_byte_access_master_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// Sequencer model: state after reset.
	function automatic void reset_model();
		bus_phase  = PH_IDLE;
		byte_step  = '0;
		bit_cnt    = '0;
		shift_reg  = '0;
		wait_cnt   = '0;
		held_addr  = '0;
		held_data  = '0;
		held_mode  = 1'b0;
		rd_byte    = '0;
		err_flag   = 1'b0;
		scl_drv    = 1'b1;
		sda_drv    = 1'b1;
		chip_sel   = 3'd0;
		poll_limit = 8'd93;
		recovery   = 16'd2500;
	endfunction

	function automatic logic [7:0] device_byte(logic [7:0] base);
		return base | {4'b0, chip_sel, 1'b0};
	endfunction

	function automatic void load_shift(logic [7:0] value);
		shift_reg = value;
		bit_cnt   = '0;
		bus_phase = PH_TX_SET;
	endfunction

	// Pick the next byte or phase once a sent byte has been acknowledged.
	function automatic void advance_byte();
		byte_step = byte_step + 3'd1;
		if (byte_step == STEP_ADDRESS) begin
			load_shift(held_addr);
		end else if (!held_mode) begin
			if (byte_step == STEP_SECOND) begin
				load_shift(held_data);
			end else begin
				bus_phase = PH_SP_SDA_LO;
			end
		end else begin
			if (byte_step == STEP_SECOND) begin
				bus_phase = PH_ST_SDA_HI;
			end else begin
				bus_phase = PH_RX_REL;
			end
		end
	endfunction

	// Advance the sequencer model by one tick and return the line levels and flags.
	function automatic result_t predict_phase_tick(tick_t t);
		logic [7:0] limit;
		logic       done;
		result_t    r;
		limit = (poll_limit == 8'd0) ? 8'd1 : poll_limit;
		done  = 1'b0;
		case (bus_phase)
			PH_IDLE: begin
				if (t.req) begin
					held_mode = t.rnw;
					held_addr = t.addr;
					held_data = t.wdata;
					err_flag  = 1'b0;
					byte_step = '0;
					bit_cnt   = '0;
					bus_phase = PH_ST_SDA_HI;
					if (t.rnw) begin
						reads_started++;
					end else begin
						writes_started++;
					end
				end
			end
			PH_ST_SDA_HI: begin
				sda_drv = 1'b1;
				bus_phase = PH_ST_SCL_HI;
			end
			PH_ST_SCL_HI: begin
				scl_drv = 1'b1;
				bus_phase = PH_ST_SDA_LO;
			end
			PH_ST_SDA_LO: begin
				sda_drv = 1'b0;
				bus_phase = PH_ST_SCL_LO;
			end
			PH_ST_SCL_LO: begin
				scl_drv = 1'b0;
				if (byte_step == STEP_SECOND) begin
					load_shift(device_byte(DEV_READ));
				end else begin
					load_shift(device_byte(DEV_WRITE));
				end
			end
			PH_TX_SET: begin
				sda_drv = shift_reg[7];
				bus_phase = PH_TX_HI;
			end
			PH_TX_HI: begin
				scl_drv = 1'b1;
				bus_phase = PH_TX_LO;
			end
			PH_TX_LO: begin
				scl_drv = 1'b0;
				shift_reg = shift_reg << 1;
				bit_cnt = bit_cnt + 4'd1;
				bus_phase = (bit_cnt >= 4'd8) ? PH_ACK_REL : PH_TX_SET;
			end
			PH_ACK_REL: begin
				sda_drv = 1'b1;
				bus_phase = PH_ACK_HI;
			end
			PH_ACK_HI: begin
				scl_drv = 1'b1;
				wait_cnt = '0;
				bus_phase = PH_ACK_POLL;
			end
			PH_ACK_POLL: begin
				if (!t.sda) begin
					scl_drv = 1'b0;
					advance_byte();
				end else begin
					wait_cnt = wait_cnt + 16'd1;
					if (wait_cnt >= {8'd0, limit} || wait_cnt == 16'd0) begin
						err_flag = 1'b1;
						scl_drv = 1'b0;
						advance_byte();
					end
				end
			end
			PH_RX_REL: begin
				sda_drv = 1'b1;
				bit_cnt = '0;
				shift_reg = '0;
				bus_phase = PH_RX_HI;
			end
			PH_RX_HI: begin
				scl_drv = 1'b1;
				bus_phase = PH_RX_SAMPLE;
			end
			PH_RX_SAMPLE: begin
				shift_reg = {shift_reg[6:0], t.sda};
				bus_phase = PH_RX_LO;
			end
			PH_RX_LO: begin
				scl_drv = 1'b0;
				bit_cnt = bit_cnt + 4'd1;
				if (bit_cnt >= 4'd8) begin
					rd_byte = shift_reg;
					bus_phase = PH_NK_SDA;
				end else begin
					bus_phase = PH_RX_HI;
				end
			end
			PH_NK_SDA: begin
				sda_drv = 1'b1;
				bus_phase = PH_NK_HI;
			end
			PH_NK_HI: begin
				scl_drv = 1'b1;
				bus_phase = PH_NK_LO;
			end
			PH_NK_LO: begin
				scl_drv = 1'b0;
				bus_phase = PH_SP_SDA_LO;
			end
			PH_SP_SDA_LO: begin
				sda_drv = 1'b0;
				bus_phase = PH_SP_SCL_HI;
			end
			PH_SP_SCL_HI: begin
				scl_drv = 1'b1;
				bus_phase = PH_SP_SDA_HI;
			end
			PH_SP_SDA_HI: begin
				sda_drv = 1'b1;
				wait_cnt = recovery;
				bus_phase = PH_WAIT;
			end
			PH_WAIT: begin
				if (wait_cnt == 16'd0) begin
					bus_phase = PH_IDLE;
					done = 1'b1;
					if (err_flag) begin
						missing_ack_xfers++;
					end
				end else begin
					wait_cnt = wait_cnt - 16'd1;
				end
			end
			default: begin
				bus_phase = PH_IDLE;
			end
		endcase
		r.scl         = scl_drv;
		r.sda         = sda_drv;
		r.busy        = (bus_phase != PH_IDLE);
		r.done        = done;
		r.read_byte   = rd_byte;
		r.ack_missing = err_flag;
		return r;
	endfunction

	// SDA level the memory would present in the phase about to run.
	function automatic logic pick_sda(ack_style_t style, logic [7:0] rx_value);
		case (bus_phase)
			PH_ACK_POLL: begin
				case (style)
					ACK_PROMPT: return 1'b0;
					ACK_SLOW:   return ($urandom_range(0, 2) != 0);
					default:    return 1'b1;
				endcase
			end
			PH_RX_SAMPLE: return rx_value[3'd7 - bit_cnt[2:0]];
			default:      return 1'($urandom_range(0, 1));
		endcase
	endfunction

	task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
		mismatches++;
		if (mismatches <= 40) begin
			$display("[%0t] tick result %0d: %s got 0x%0h, expected 0x%0h",
				$time, checked, field, got, want);
		end
	endtask

	// Result checker: every accepted result against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (tick_results_due.size() == 0) begin
				report_mismatch("result with no tick pending", m_tdata, 16'd0);
			end else begin
				want_res = tick_results_due.pop_front();
				seen_res = result_t'(m_tdata[12:0]);
				if (seen_res.scl != want_res.scl)
					report_mismatch("scl_level", 16'(seen_res.scl), 16'(want_res.scl));
				if (seen_res.sda != want_res.sda)
					report_mismatch("sda_level", 16'(seen_res.sda), 16'(want_res.sda));
				if (seen_res.busy != want_res.busy)
					report_mismatch("busy_res", 16'(seen_res.busy), 16'(want_res.busy));
				if (seen_res.done != want_res.done)
					report_mismatch("done_res", 16'(seen_res.done), 16'(want_res.done));
				if (seen_res.read_byte != want_res.read_byte)
					report_mismatch("read_byte", 16'(seen_res.read_byte),
						16'(want_res.read_byte));
				if (seen_res.ack_missing != want_res.ack_missing)
					report_mismatch("ack_missing", 16'(seen_res.ack_missing),
						16'(want_res.ack_missing));
				checked++;
			end
		end
	end

	// Result receiver: each ready pattern runs for a random age, then a new one is picked.
	always @(posedge clk) begin
		if (sink_age == 0) begin
			sink_age  = $urandom_range(16, 200);
			sink_mode = sink_mode_t'($urandom_range(0, 2));
			sink_mask = 8'($urandom_range(0, 255)) | 8'h01;
		end
		sink_age--;
		case (sink_mode)
			SINK_OPEN:   m_tready <= 1'b1;
			SINK_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
			default: begin
				m_tready <= sink_mask[0];
				sink_mask = {sink_mask[0], sink_mask[7:1]};
			end
		endcase
	end

	// Send one tick request in bursts with random gaps, then predict its result.
	task automatic send_tick(input tick_t t);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 2) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, t};
		do @(posedge clk); while (!s_tready);
		tick_results_due.push_back(predict_phase_tick(t));
		ticks_sent++;
	endtask

	// Stop sending and let every predicted result come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (tick_results_due.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_register(input logic [1:0] idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_CHIP_SELECT:    chip_sel = value[2:0];
			REG_ACK_POLL_LIMIT: poll_limit = value[7:0];
			REG_RECOVERY_TICKS: recovery = value;
			default: ;
		endcase
		settings_applied++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [2:0] cs, input logic [7:0] limit,
			input logic [15:0] recov);
		drain_results();
		set_register(REG_CHIP_SELECT, {13'd0, cs});
		set_register(REG_ACK_POLL_LIMIT, {8'd0, limit});
		set_register(REG_RECOVERY_TICKS, recov);
	endtask

	// Ticks with no request while the sequencer sits idle.
	task automatic idle_ticks(input int count);
		tick_t t;
		repeat (count) begin
			t = tick_t'($urandom);
			t.req = 1'b0;
			send_tick(t);
		end
	endtask

	// One whole transfer: the starting request, then ticks until the block is idle.
	task automatic run_transfer(input logic rnw, input logic [7:0] addr,
			input logic [7:0] data, input ack_style_t style,
			input logic [7:0] rx_value, input int busy_req_pct);
		tick_t t;
		t.req   = 1'b1;
		t.rnw   = rnw;
		t.addr  = addr;
		t.wdata = data;
		t.sda   = 1'($urandom_range(0, 1));
		send_tick(t);
		while (bus_phase != PH_IDLE) begin
			t.req   = ($urandom_range(0, 99) < busy_req_pct);
			t.rnw   = 1'($urandom_range(0, 1));
			t.addr  = 8'($urandom_range(0, 255));
			t.wdata = 8'($urandom_range(0, 255));
			t.sda   = pick_sda(style, rx_value);
			send_tick(t);
		end
	endtask

	// Chip select 0 and poll limit 93 after reset; only the recovery count is shortened.
	task automatic test_reset_defaults();
		idle_ticks(4);
		drain_results();
		set_register(REG_RECOVERY_TICKS, 16'd1);
		run_transfer(1'b0, 8'h5A, 8'hC3, ACK_SLOW, 8'h00, 0);
	endtask

	// Address and data extremes under both chip select extremes, with an all-ones read byte.
	task automatic test_field_extremes();
		configure(3'd7, 8'd1, 16'd0);
		run_transfer(1'b0, 8'hFF, 8'h00, ACK_PROMPT, 8'h00, 0);
		// A poll limit of zero behaves as a limit of one.
		configure(3'd0, 8'd0, 16'd0);
		run_transfer(1'b1, 8'h00, 8'hFF, ACK_NONE, 8'hFF, 0);
	endtask

	// Every sent byte waits out a long acknowledge poll and times out.
	task automatic test_ack_timeouts();
		configure(3'd5, 8'd10, 16'd1);
		run_transfer(1'b0, 8'h81, 8'h7E, ACK_NONE, 8'h00, 0);
	endtask

	// A longer recovery wait, with the sender held off until all results are back.
	task automatic test_long_recovery();
		configure(3'd2, 8'd2, 16'd30);
		run_transfer(1'b1, 8'h42, 8'h24, ACK_PROMPT, 8'h69, 0);
		drain_results();
	endtask

	// Requests on every busy tick are ignored until the transfer is done.
	task automatic test_busy_requests();
		configure(3'd3, 8'd3, 16'd0);
		run_transfer(1'b1, 8'h56, 8'h78, ACK_SLOW, 8'hC7, 100);
	endtask

	// Random transfers under changing register settings.
	task automatic test_random_traffic();
		int         pick;
		ack_style_t style;
		do begin
			if ($urandom_range(0, 3) == 0) begin
				configure(3'($urandom_range(0, 7)), 8'($urandom_range(1, 8)),
					16'($urandom_range(0, 10)));
			end else if ($urandom_range(0, 7) == 0) begin
				drain_results();
			end
			idle_ticks($urandom_range(0, 3));
			pick = $urandom_range(0, 19);
			style = (pick < 10) ? ACK_PROMPT : (pick < 17) ? ACK_SLOW : ACK_NONE;
			run_transfer(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), style, 8'($urandom_range(0, 255)),
				$urandom_range(0, 30));
		end while (ticks_sent < 700);
	endtask

	initial begin
		reset_model();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_defaults();
		test_field_extremes();
		test_ack_timeouts();
		test_long_recovery();
		test_busy_requests();
		test_random_traffic();
		drain_results();
		$display("Checked %0d tick results: %0d byte writes, %0d random reads,",
			checked, writes_started, reads_started);
		$display("%0d with an ACK timeout; register writes: %0d; mismatches found: %0d.",
			missing_ack_xfers, settings_applied, mismatches);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#1_000_000;
		$display("Watchdog expired with %0d results still pending.", tick_results_due.size());
		$display("TB_ERROR");
		$finish;
	end

endmodule
